>>> rtl/core/deq_pkg.sv
// deque package: opcodes, status codes, result struct and defaults
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic                     is_empty;
        stat_t                    status;
    } res_t;

endpackage

>>> rtl/core/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit values in a ring of DEPTH
// entries held in one synchronous ram, with the front and back values
// cached in registers. Pushes, clears, refused operations and pops that
// leave fewer than two entries are registered straight into the output
// register; a pop that leaves two or more entries first passes the
// read state, since the new end value is fetched through the ram read port.
// One operation is in flight at a time; the result sits in an output
// register and the next input beat is taken in the cycle that it leaves.
// s_tuser carries the opcode, s_tdata the push value.
`timescale 1ns / 1ps

module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1),
    localparam int OUT_W  = 3 * DATA_W + CNT_W + 1 + STAT_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,  // push_value
    input  logic [OP_W-1:0]   s_tuser,  // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    // popped_value, front_value, back_value, count, is_empty, status, zero pad
    output logic [OUT_TW-1:0] m_tdata
);

    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_free;
    logic              res_valid;
    res_t              res;
    logic [CNT_W-1:0]  res_count;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign out_free = !out_valid_reg || m_tready;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .res_count (res_count),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the controller only raises res_valid when the output register is free
    always_comb
    begin
        priority if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg   <= res;
            out_count_reg <= res_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'({out_res_reg.status, out_res_reg.is_empty, out_count_reg,
                               out_res_reg.back, out_res_reg.front, out_res_reg.popped});

endmodule

>>> rtl/core/deq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/deq_ctrl.sv
// deque control: end pointers, count, cached end values and read sequencing
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          in_op,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic                     out_free,
    output logic                     res_valid,
    output res_t                     res,
    output logic [CNT_W-1:0]         res_count,
    output logic                     wr_en,
    output logic [IDX_W-1:0]         wr_addr,
    output logic [DATA_W-1:0]        wr_data,
    output logic                     rd_en,
    output logic [IDX_W-1:0]         rd_addr,
    input  logic [DATA_W-1:0]        rd_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         front_idx_reg, front_idx_next;
    logic [IDX_W-1:0]         back_idx_reg, back_idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] front_val_reg, front_val_next;
    logic signed [DATA_W-1:0] back_val_reg, back_val_next;
    logic signed [DATA_W-1:0] pend_pop_reg, pend_pop_next;
    logic                     pend_front_reg, pend_front_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
    stat_t            stat;
    logic signed [DATA_W-1:0] popped;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // ring neighbors, wrap at the last entry
    assign front_inc = (front_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : front_idx_reg + 1'b1;
    assign front_dec = (front_idx_reg == '0) ? IDX_W'(DEPTH - 1) : front_idx_reg - 1'b1;
    assign back_inc  = (back_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : back_idx_reg + 1'b1;
    assign back_dec  = (back_idx_reg == '0) ? IDX_W'(DEPTH - 1) : back_idx_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        front_idx_next  = front_idx_reg;
        back_idx_next   = back_idx_reg;
        count_next      = count_reg;
        front_val_next  = front_val_reg;
        back_val_next   = back_val_reg;
        pend_pop_next   = pend_pop_reg;
        pend_front_next = pend_front_reg;
        wr_en           = 1'b0;
        wr_addr         = front_idx_reg;
        wr_data         = in_value;
        rd_en           = 1'b0;
        rd_addr         = front_inc;
        res_valid       = 1'b0;
        stat            = ST_OK;
        popped          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_valid = 1'b1;
                    unique case (in_op)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                stat = ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = front_dec;
                                front_idx_next = front_dec;
                                front_val_next = in_value;
                                if (is_empty)
                                begin
                                    back_idx_next = front_dec;
                                    back_val_next = in_value;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                stat = ST_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (is_empty)
                                begin
                                    wr_addr        = front_idx_reg;
                                    back_idx_next  = front_idx_reg;
                                    front_val_next = in_value;
                                end
                                else
                                begin
                                    wr_addr       = back_inc;
                                    back_idx_next = back_inc;
                                end
                                back_val_next = in_value;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                stat = ST_EMPTY;
                            end
                            else
                            begin
                                popped     = front_val_reg;
                                count_next = count_reg - 1'b1;
                                if (count_reg == CNT_W'(1))
                                begin
                                    front_idx_next = '0;
                                    back_idx_next  = '0;
                                end
                                else
                                begin
                                    front_idx_next = front_inc;
                                    if (count_reg == CNT_W'(2))
                                    begin
                                        front_val_next = back_val_reg;
                                    end
                                    else
                                    begin
                                        // new front lives only in the ram
                                        rd_en           = 1'b1;
                                        rd_addr         = front_inc;
                                        res_valid       = 1'b0;
                                        pend_pop_next   = front_val_reg;
                                        pend_front_next = 1'b1;
                                        state_next      = S_READ;
                                    end
                                end
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                stat = ST_EMPTY;
                            end
                            else
                            begin
                                popped     = back_val_reg;
                                count_next = count_reg - 1'b1;
                                if (count_reg == CNT_W'(1))
                                begin
                                    front_idx_next = '0;
                                    back_idx_next  = '0;
                                end
                                else
                                begin
                                    back_idx_next = back_dec;
                                    if (count_reg == CNT_W'(2))
                                    begin
                                        back_val_next = front_val_reg;
                                    end
                                    else
                                    begin
                                        rd_en           = 1'b1;
                                        rd_addr         = back_dec;
                                        res_valid       = 1'b0;
                                        pend_pop_next   = back_val_reg;
                                        pend_front_next = 1'b0;
                                        state_next      = S_READ;
                                    end
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            front_idx_next = '0;
                            back_idx_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_valid = 1'b1;
                popped    = pend_pop_reg;
                if (pend_front_reg)
                begin
                    front_val_next = rd_data;
                end
                else
                begin
                    back_val_next = rd_data;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.popped   = popped;
        res.is_empty = (count_next == '0);
        res.front    = res.is_empty ? '0 : front_val_next;
        res.back     = res.is_empty ? '0 : back_val_next;
        res.status   = stat;
        res_count    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_idx_reg <= '0;
            back_idx_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg  <= front_val_next;
        back_val_reg   <= back_val_next;
        pend_pop_reg   <= pend_pop_next;
        pend_front_reg <= pend_front_next;
    end

endmodule
